// ===== hw/rtl/tps_pkg.sv =====
// tps_pkg: types, pattern codes and step tables for the tone pattern sequencer
// no dependencies; used by tps_player and tone_pattern_sequencer_unit
package tps_pkg;

   localparam int unsigned HzW   = 12;
   localparam int unsigned MsW   = 9;
   localparam int unsigned StepW = 3;

   localparam logic [7:0] PAT_STOP   = 8'd0;
   localparam logic [7:0] PAT_DOUBLE = 8'd2;
   localparam logic [7:0] PAT_ALARM  = 8'd3;
   localparam logic [7:0] PAT_CHIRP  = 8'd4;

   localparam logic [31:0] REPEAT_GAP_MS = 32'd80;

   localparam logic [HzW-1:0] HZ_OFF  = 12'd0;
   localparam logic [HzW-1:0] HZ_LOW  = 12'd1400;
   localparam logic [HzW-1:0] HZ_MID  = 12'd2200;
   localparam logic [HzW-1:0] HZ_HIGH = 12'd2400;
   localparam logic [HzW-1:0] HZ_TOP  = 12'd3000;

   typedef struct packed {
      logic [HzW-1:0] hz;
      logic [MsW-1:0] ms;   // zero marks the terminator
   } step_type;

   typedef struct packed {
      logic        action;
      logic [31:0] now_ms;
      logic [7:0]  pattern;
      logic [7:0]  repeats;
   } req_type;

   typedef struct packed {
      logic [HzW-1:0] tone_hz;
      logic           active;
   } rsp_type;

   function automatic step_type step_lookup(input logic [7:0] pattern,
                                            input logic [StepW-1:0] idx);
      step_type s;
      s = '{hz: HZ_OFF, ms: 9'd0};
      case (pattern)
         PAT_DOUBLE: begin
            case (idx)
               3'd0:    s = '{hz: HZ_MID, ms: 9'd40};
               3'd1:    s = '{hz: HZ_OFF, ms: 9'd60};
               3'd2:    s = '{hz: HZ_MID, ms: 9'd40};
               default: s = '{hz: HZ_OFF, ms: 9'd0};
            endcase
         end
         PAT_ALARM: begin
            case (idx)
               3'd0:    s = '{hz: HZ_LOW, ms: 9'd200};
               3'd1:    s = '{hz: HZ_OFF, ms: 9'd120};
               3'd2:    s = '{hz: HZ_LOW, ms: 9'd200};
               3'd3:    s = '{hz: HZ_OFF, ms: 9'd400};
               default: s = '{hz: HZ_OFF, ms: 9'd0};
            endcase
         end
         PAT_CHIRP: begin
            case (idx)
               3'd0:    s = '{hz: HZ_TOP,  ms: 9'd25};
               3'd1:    s = '{hz: HZ_OFF,  ms: 9'd25};
               3'd2:    s = '{hz: HZ_HIGH, ms: 9'd25};
               default: s = '{hz: HZ_OFF,  ms: 9'd0};
            endcase
         end
         default: begin
            case (idx)
               3'd0:    s = '{hz: HZ_MID, ms: 9'd40};
               default: s = '{hz: HZ_OFF, ms: 9'd0};
            endcase
         end
      endcase
      return s;
   endfunction

endpackage

// ===== hw/rtl/tone_pattern_sequencer_unit.sv =====
// tone_pattern_sequencer_unit: buzzer pattern player, input and result registers
// depends on tps_pkg and tps_player
//
// Usage: each req transaction is either a start (req_action = 1, with
// req_pattern and req_repeats) or a poll (req_action = 0, with req_now_ms).
// Every transaction gives exactly one rsp transaction carrying the tone now
// driven (rsp_tone_hz, 0 = silent) and whether a pattern is still playing.
// A transaction is registered in the input register, processed once the result
// register is empty or not stalled, and its result then shows on rsp_valid from
// the result register. Throughput: one transaction per clock while rsp_stall is
// low; the step lookup, the 32-bit deadline compare and the deadline add all sit
// between the input register and the result register.
// Reset clears the pattern state (idle, silent, deadline zero) and empties
// both registers. While rsp_stall holds a waiting result, the input register
// can still fill once; after that req_stall rises until the result is taken.
module tone_pattern_sequencer_unit
   import tps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_action,
   input  logic [31:0]       req_now_ms,
   input  logic [7:0]        req_pattern,
   input  logic [7:0]        req_repeats,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [HzW-1:0]    rsp_tone_hz,
   output logic              rsp_active
);

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff;
   rsp_type result;
   logic    fire;
   logic    req_take;

   assign fire      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   tps_player u_player (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= '{action: req_action, now_ms: req_now_ms,
                         pattern: req_pattern, repeats: req_repeats};
      end
      if (fire) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_tone_hz = out_item_ff.tone_hz;
   assign rsp_active  = out_item_ff.active;

   // idle player is always silent
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_active) |-> (rsp_tone_hz == HZ_OFF))
      else $error("idle result carries a tone");

   // only table frequencies reach the buzzer
   a_tone_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tone_hz == HZ_OFF || rsp_tone_hz == HZ_LOW ||
                     rsp_tone_hz == HZ_MID || rsp_tone_hz == HZ_HIGH ||
                     rsp_tone_hz == HZ_TOP))
      else $error("tone outside the step tables");

   // a processed transaction always lands in the result register
   a_fire_lands: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("processed transaction lost");

endmodule

// ===== hw/rtl/tps_player.sv =====
// tps_player: pattern state registers and the per-transaction step logic
// depends on tps_pkg (types, step tables)
module tps_player
   import tps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type item,
   output rsp_type result
);

   logic [7:0]       pattern_ff, pattern_in;
   logic [7:0]       repeats_ff, repeats_in;
   logic [StepW-1:0] step_ff, step_in;
   logic [31:0]      due_ff, due_in;
   logic [HzW-1:0]   tone_ff, tone_in;
   step_type         cur_step;
   logic [7:0]       repeats_dec;

   assign cur_step    = step_lookup(pattern_ff, step_ff);
   assign repeats_dec = (repeats_ff != 8'd0) ? repeats_ff - 8'd1 : 8'd0;

   always_comb begin
      pattern_in = pattern_ff;
      repeats_in = repeats_ff;
      step_in    = step_ff;
      due_in     = due_ff;
      tone_in    = tone_ff;
      if (item.action) begin
         pattern_in = item.pattern;
         repeats_in = (item.repeats == 8'd0) ? 8'd1 : item.repeats;
         step_in    = '0;
         due_in     = '0;
         if (item.pattern == PAT_STOP) begin
            tone_in = HZ_OFF;
         end
      end else if (pattern_ff != PAT_STOP && item.now_ms >= due_ff) begin
         if (cur_step.ms == '0) begin
            // end of one repetition: silence, rewind, gap before the next
            tone_in    = HZ_OFF;
            step_in    = '0;
            repeats_in = repeats_dec;
            if (repeats_dec == 8'd0) begin
               pattern_in = PAT_STOP;
            end
            due_in = item.now_ms + REPEAT_GAP_MS;
         end else begin
            tone_in = cur_step.hz;
            step_in = step_ff + 3'd1;
            due_in  = item.now_ms + {23'd0, cur_step.ms};
         end
      end
   end

   assign result.tone_hz = tone_in;
   assign result.active  = (pattern_in != PAT_STOP);

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= PAT_STOP;
         repeats_ff <= '0;
         step_ff    <= '0;
         due_ff     <= '0;
         tone_ff    <= HZ_OFF;
      end else if (fire) begin
         pattern_ff <= pattern_in;
         repeats_ff <= repeats_in;
         step_ff    <= step_in;
         due_ff     <= due_in;
         tone_ff    <= tone_in;
      end
   end

endmodule
